// ===== hw/rtl/fixed_step_accumulator_macros.svh =====
// Assertion macros shared by the fixed step accumulator RTL.
// Both expect clk_i and the active-low reset rst_ni in the including module.
`ifndef FIXED_STEP_ACCUMULATOR_MACROS_SVH
`define FIXED_STEP_ACCUMULATOR_MACROS_SVH

// Plain property, checked on every clock edge outside reset
`define FSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset
`define FSA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ===== hw/rtl/fsa_pkg.sv =====
// Package for the fixed step accumulator: widths, reset values, register
// indexes and the structs passed between the top level and the core.
// No dependencies.
package fsa_pkg;

  // Field widths
  localparam int TIME_WIDTH      = 48;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int STEP_W          = 40;
  localparam int CATCH_W         = 8;
  localparam int BANK_W          = 56;
  localparam int TICK_W          = 32;
  localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;

  // Bank plus clamped delta, one carry bit on top
  localparam int DELTA_MAG_W = TIME_WIDTH - 1;
  localparam int SUM_W       = ((BANK_W > DELTA_MAG_W) ? BANK_W : DELTA_MAG_W) + 1;

  // Shared subtractor width: bank plus a sign bit
  localparam int OP_W = BANK_W + 1;

  // Divide bit counter
  localparam int DIV_CNT_W = (ALPHA_FRAC_BITS > 1) ? $clog2(ALPHA_FRAC_BITS) : 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CATCHUP = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]  STEP_RESET    = STEP_W'(71582788);
  localparam logic [CATCH_W-1:0] CATCHUP_RESET = CATCH_W'(8);

  // Configuration as seen by the core (step already forced nonzero)
  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [CATCH_W-1:0] max_catchup;
  } fsa_cfg_t;

  // One result transaction
  typedef struct packed {
    logic [TICK_W-1:0]  first_tick;
    logic [CATCH_W-1:0] tick_count;
    logic [ALPHA_W-1:0] blend_alpha;
  } fsa_res_t;

endpackage

// ===== hw/rtl/fsa_core.sv =====
// Sequencer and shared subtractor of the fixed step accumulator: bank
// update, repeated step subtraction and restoring divide for the alpha.
// Depends on fsa_pkg and fixed_step_accumulator_macros.svh.
`include "fixed_step_accumulator_macros.svh"

module fsa_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [fsa_pkg::TIME_WIDTH-1:0]     delta_i,
  input  fsa_pkg::fsa_cfg_t                  cfg_i,
  input  logic                               take_i,
  output logic                               busy_o,
  output logic                               done_o,
  output fsa_pkg::fsa_res_t                  res_o
);
  import fsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [BANK_W-1:0]        bank_q, bank_d;
  logic [TICK_W-1:0]        tick_q, tick_d;
  logic [TICK_W-1:0]        first_q, first_d;
  logic [CATCH_W-1:0]       cnt_q, cnt_d;
  logic [STEP_W-1:0]        rem_q, rem_d;
  logic [ALPHA_FRAC_BITS-1:0] quot_q, quot_d;
  logic [DIV_CNT_W-1:0]     bit_q, bit_d;
  logic [ALPHA_W-1:0]       alpha_q, alpha_d;

  logic [DELTA_MAG_W-1:0]   delta_pos;
  logic [SUM_W-1:0]         sum;
  logic [BANK_W-1:0]        bank_sat;
  logic [OP_W-1:0]          operand;
  logic [OP_W-1:0]          diff;
  logic                     ge;

  // Negative delta counts as zero; bank saturates
  assign delta_pos = delta_i[TIME_WIDTH-1] ? '0 : delta_i[DELTA_MAG_W-1:0];
  assign sum       = SUM_W'(bank_q) + SUM_W'(delta_pos);
  assign bank_sat  = (|sum[SUM_W-1:BANK_W]) ? '1 : sum[BANK_W-1:0];

  // Shared subtractor: bank while stepping, shifted remainder while dividing
  assign operand = (state_q == ST_STEP) ? {1'b0, bank_q} : OP_W'({rem_q, 1'b0});
  assign diff    = operand - OP_W'(cfg_i.step);
  assign ge      = ~diff[OP_W-1];

  // Sequencer
  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    tick_d  = tick_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    bit_d   = bit_q;
    alpha_d = alpha_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          bank_d  = bank_sat;
          first_d = tick_q;
          cnt_d   = '0;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (ge && (cnt_q != cfg_i.max_catchup)) begin
          bank_d = diff[BANK_W-1:0];
          cnt_d  = cnt_q + CATCH_W'(1);
          tick_d = tick_q + TICK_W'(1);
        end else if (ge) begin
          // limit reached with a full step still banked
          alpha_d = ALPHA_ONE;
          state_d = ST_DONE;
        end else begin
          rem_d   = bank_q[STEP_W-1:0];
          quot_d  = '0;
          bit_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? diff[STEP_W-1:0] : operand[STEP_W-1:0];
        quot_d = {quot_q[ALPHA_FRAC_BITS-2:0], ge};
        bit_d  = bit_q + DIV_CNT_W'(1);
        if (bit_q == DIV_CNT_W'(ALPHA_FRAC_BITS - 1)) begin
          alpha_d = {1'b0, quot_q[ALPHA_FRAC_BITS-2:0], ge};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bank_q  <= '0;
      tick_q  <= '0;
      first_q <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      quot_q  <= '0;
      bit_q   <= '0;
      alpha_q <= '0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      tick_q  <= tick_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      quot_q  <= quot_d;
      bit_q   <= bit_d;
      alpha_q <= alpha_d;
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = (state_q == ST_DONE);
  assign res_o.first_tick  = first_q;
  assign res_o.tick_count  = cnt_q;
  assign res_o.blend_alpha = alpha_q;

  // Checks
  `FSA_ASSERT_IMPL(a_cnt_limit, state_q == ST_STEP, cnt_q <= cfg_i.max_catchup, "step count past catch-up limit")
  `FSA_ASSERT_IMPL(a_rem_below_step, state_q == ST_DIV, rem_q < cfg_i.step, "divide remainder not below step")
  `FSA_ASSERT_IMPL(a_tick_sum, state_q == ST_DONE, tick_q == (first_q + TICK_W'(cnt_q)), "tick index out of step with count")

endmodule

// ===== hw/rtl/fixed_step_accumulator.sv =====
// Top level of the fixed step accumulator: ports, configuration registers
// and the output register. Depends on fsa_pkg, fsa_core and the macro header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / frame_delta_i): one transaction
//   per frame, carrying the signed elapsed time with 32 fraction bits.
//   Output channel (out_valid_o / out_stall_i): one transaction per input,
//   carrying first_tick_o, tick_count_o and blend_alpha_o (Q1.16).
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   index 0 is the fixed step, index 1 the catch-up limit; other indexes are
//   ignored. Write only while no transaction is in flight.
// Sequence:
//   After acceptance the core subtracts the step once per tick, up to the
//   catch-up limit, makes a final compare and runs the restoring divide for
//   the 16 alpha fraction bits (skipped when the limit leaves a full step
//   banked), all on one shared 57-bit subtractor, then loads the output
//   register. Input stall stays high until the result is loaded, so no new
//   frame is accepted while the previous one is still in the core.
// Reset clears the bank, tick index and output valid and loads the default step
// and limit. A stalled output holds its transaction; the core waits behind it.
`include "fixed_step_accumulator_macros.svh"

module fixed_step_accumulator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [fsa_pkg::TIME_WIDTH-1:0]        frame_delta_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [fsa_pkg::TICK_W-1:0]            first_tick_o,
  output logic [fsa_pkg::CATCH_W-1:0]           tick_count_o,
  output logic [fsa_pkg::ALPHA_W-1:0]           blend_alpha_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [fsa_pkg::STEP_W-1:0]            cfg_data_i
);
  import fsa_pkg::*;

  logic [STEP_W-1:0]  step_q, step_d;
  logic [CATCH_W-1:0] catchup_q, catchup_d;
  fsa_cfg_t           cfg;
  logic               start, take, busy, done;
  fsa_res_t           res;
  fsa_res_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    step_d    = step_q;
    catchup_d = catchup_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IDX_STEP:    step_d    = cfg_data_i;
        CFG_IDX_CATCHUP: catchup_d = cfg_data_i[CATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero step acts as one
  assign cfg.step        = (step_q == '0) ? STEP_W'(1) : step_q;
  assign cfg.max_catchup = catchup_q;

  // Input transaction
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  // Output register loads when empty or being drained
  assign take        = done && (!out_valid_q || !out_stall_i);
  assign out_d       = take ? res : out_q;
  assign out_valid_d = take ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      catchup_q   <= CATCHUP_RESET;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      catchup_q   <= catchup_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  fsa_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .delta_i (frame_delta_i),
    .cfg_i   (cfg),
    .take_i  (take),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res)
  );

  assign out_valid_o   = out_valid_q;
  assign first_tick_o  = out_q.first_tick;
  assign tick_count_o  = out_q.tick_count;
  assign blend_alpha_o = out_q.blend_alpha;

  // Checks
  `FSA_ASSERT_IMPL(a_alpha_max, out_valid_o, blend_alpha_o <= ALPHA_ONE, "alpha above one")
  `FSA_ASSERT_IMPL(a_count_max, out_valid_o, tick_count_o <= catchup_q, "tick count above limit")
  `FSA_ASSERT(a_no_start_busy, !(start && busy), "start while core busy")

endmodule
